/* src/u8d_pkg.sv */
// Shared types and constants of the UTF-8 stream decoder.
package u8d_pkg;

    localparam int CpW    = 21;
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    localparam logic [CpW-1:0] SubstChar  = CpW'(8'h2E);
    localparam logic [31:0]    LimitReset = 32'hFFFF_FFFF;

    typedef struct packed {
        logic           two;
        logic [CpW-1:0] cp;
        logic           subst;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

endpackage

/* src/utf8_stream_decoder.sv */
// UTF-8 stream decoder top level: front end, result queue and output stage.
// A result enters the queue as its byte is accepted, then the output register.
// Throughput: one byte per cycle while the queue has room and the limit is not hit;
// a byte with two results holds the output for both; the four-entry queue absorbs it.
// Reset: synchronous active low; clears decode state, byte count, queue and output
// valid, and sets the length limit to all ones (unlimited). No clearing pass.
module utf8_stream_decoder (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_byte_in,
    input  logic                    i_chunk_end,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [u8d_pkg::CpW-1:0] o_code_point,
    output logic                    o_substituted,
    output logic                    o_last,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [31:0]             i_cfg_data
);
    import u8d_pkg::*;

    logic    q_full;
    logic    push;
    logic    pop;
    t_entry  push_entry;
    t_q_head head;

    u8d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_byte_in    (i_byte_in),
        .i_chunk_end  (i_chunk_end),
        .o_stall      (o_stall),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    u8d_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head       (head)
    );

    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_substituted (o_substituted),
        .o_last        (o_last)
    );

endmodule

/* src/u8d_front.sv */
// Front end: byte acceptance, length limit, sequence decode and queue push.
module u8d_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte_in,
    input  logic                 i_chunk_end,
    output logic                 o_stall,
    input  logic                 i_cfg_valid,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_cfg_ready,
    input  logic                 i_q_full,
    output logic                 o_push,
    output u8d_pkg::t_entry      o_push_entry
);
    import u8d_pkg::*;

    logic [31:0]    r_limit;
    logic [31:0]    r_consumed;
    logic [31:0]    n_consumed;
    logic [1:0]     r_pending;
    logic [1:0]     n_pending;
    logic [CpW-1:0] r_acc;
    logic [CpW-1:0] n_acc;
    logic [CpW-1:0] shifted;
    logic           limit_hit;
    logic           take;
    logic           push;
    t_entry         entry;

    assign o_stall     = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign limit_hit   = (r_limit != LimitReset) && (r_consumed >= r_limit);
    assign take        = i_valid && !i_q_full && !limit_hit;
    assign shifted     = {r_acc[CpW-7:0], i_byte_in[5:0]};

    always_comb begin
        n_pending   = r_pending;
        n_acc       = r_acc;
        push        = 1'b0;
        entry.two   = 1'b0;
        entry.cp    = SubstChar;
        entry.subst = 1'b1;
        n_consumed  = (r_consumed != LimitReset) ? r_consumed + 32'd1 : r_consumed;
        unique casez (i_byte_in)
            8'b0???_???? : begin
                push        = 1'b1;
                entry.two   = (r_pending != 2'd0);
                entry.cp    = CpW'(i_byte_in);
                entry.subst = 1'b0;
                n_pending   = 2'd0;
            end
            8'b10??_???? : begin
                if (r_pending != 2'd0) begin
                    n_acc     = shifted;
                    n_pending = r_pending - 2'd1;
                    if (r_pending == 2'd1) begin
                        push        = 1'b1;
                        entry.cp    = shifted;
                        entry.subst = 1'b0;
                    end
                end else begin
                    push = 1'b1;
                end
            end
            8'b110?_???? : begin
                n_pending = 2'd1;
                n_acc     = CpW'(i_byte_in & 8'h1F);
            end
            8'b1110_???? : begin
                n_pending = 2'd2;
                n_acc     = CpW'(i_byte_in & 8'h0F);
            end
            8'b1111_0??? : begin
                n_pending = 2'd3;
                n_acc     = CpW'(i_byte_in & 8'h07);
            end
            default : begin
                push      = 1'b1;
                n_pending = 2'd0;
            end
        endcase
    end

    assign o_push       = take && push && (i_chunk_end || !i_chunk_end);
    assign o_push_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LimitReset;
            r_consumed <= 32'd0;
            r_pending  <= 2'd0;
            r_acc      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (take) begin
                r_consumed <= n_consumed;
                r_pending  <= n_pending;
                r_acc      <= n_acc;
            end
        end
    end

endmodule

/* src/u8d_queue.sv */
// Short result queue between the front end and the output stage.
module u8d_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u8d_pkg::t_entry  i_push_entry,
    input  logic             i_pop,
    output logic             o_full,
    output u8d_pkg::t_q_head o_head
);
    import u8d_pkg::*;

    t_entry         r_mem [QDepth];
    logic [QAw-1:0] r_wr_ptr;
    logic [QAw-1:0] r_rd_ptr;
    logic [QAw:0]   r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full       = (r_count == (QAw+1)'(QDepth));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QAw'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QAw'(1);
            end
            r_count <= r_count + (QAw+1)'(do_push) - (QAw+1)'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAw+1)'(QDepth))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");
`endif

endmodule

/* src/u8d_back.sv */
// Output stage: expands queue entries into result transactions.
module u8d_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  u8d_pkg::t_q_head        i_head,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [u8d_pkg::CpW-1:0] o_code_point,
    output logic                    o_substituted,
    output logic                    o_last
);
    import u8d_pkg::*;

    logic           r_valid;
    logic           r_phase;
    logic [CpW-1:0] r_cp;
    logic           r_subst;
    logic           r_last;
    logic           load;
    logic           first_half;

    assign load       = i_head.valid && (!r_valid || !i_stall);
    assign first_half = i_head.entry.two && !r_phase;
    assign o_pop      = load && !first_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_phase <= first_half;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (first_half) begin
                r_cp    <= SubstChar;
                r_subst <= 1'b1;
                r_last  <= 1'b0;
            end else begin
                r_cp    <= i_head.entry.cp;
                r_subst <= i_head.entry.subst;
                r_last  <= 1'b1;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_code_point  = r_cp;
    assign o_substituted = r_subst;
    assign o_last        = r_last;

endmodule
